/* rtl/core/cid_pkg.sv */
// Shared constants and types for the CBOR item delimiter.
package cid_pkg;

	// Result status codes
	localparam logic [2:0] ST_BUSY     = 3'd0;
	localparam logic [2:0] ST_DONE     = 3'd1;
	localparam logic [2:0] ST_TRAIL    = 3'd2;
	localparam logic [2:0] ST_END      = 3'd3;
	localparam logic [2:0] ST_RESERVED = 3'd4;
	localparam logic [2:0] ST_TYPE     = 3'd5;
	localparam logic [2:0] ST_TOOLONG  = 3'd6;
	localparam logic [2:0] ST_NESTING  = 3'd7;

	// Major types
	localparam logic [2:0] MAJ_UINT = 3'd0;
	localparam logic [2:0] MAJ_BSTR = 3'd2;
	localparam logic [2:0] MAJ_TSTR = 3'd3;
	localparam logic [2:0] MAJ_ARR  = 3'd4;
	localparam logic [2:0] MAJ_MAP  = 3'd5;

	localparam logic [7:0] SIMPLE_FALSE = 8'hf4;
	localparam logic [7:0] SIMPLE_TRUE  = 8'hf5;
	localparam logic [4:0] INFO_ONE_BYTE   = 5'd24;
	localparam logic [4:0] INFO_EIGHT_BYTE = 5'd27;

	// Configuration register indexes
	localparam logic REG_MSG_LENGTH  = 1'b0;
	localparam logic REG_DEPTH_LIMIT = 1'b1;

	localparam logic [31:0] MSG_LENGTH_RST  = 32'd1;
	localparam logic [9:0]  DEPTH_LIMIT_RST = 10'd520;

	localparam int STACK_DEPTH_DEF = 1024;
	localparam int FQ_DEPTH_DEF    = 4;

	// Byte with its initial-byte classification
	typedef struct packed {
		logic [7:0] data;
		logic       simple;
		logic       bad_type;
		logic       reserved;
	} byte_cls_t;

endpackage

/* rtl/core/cid_front.sv */
// Front end: takes input beats, classifies them and queues them for the back end.
module cid_front #(
	parameter int QDEPTH = cid_pkg::FQ_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        data_byte,
	output cid_pkg::byte_cls_t head,
	output logic              head_valid,
	input  logic              head_take
);
	localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	cid_pkg::byte_cls_t q_mem [QDEPTH];
	cid_pkg::byte_cls_t cls;
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          wr_fire, rd_fire;
	logic [2:0]    maj;

	always_comb begin
		maj = data_byte[7:5];
		cls.data = data_byte;
		cls.simple = (data_byte == cid_pkg::SIMPLE_FALSE) || (data_byte == cid_pkg::SIMPLE_TRUE);
		cls.bad_type = !cls.simple && !((maj == cid_pkg::MAJ_UINT) || (maj == cid_pkg::MAJ_BSTR)
			|| (maj == cid_pkg::MAJ_TSTR) || (maj == cid_pkg::MAJ_ARR)
			|| (maj == cid_pkg::MAJ_MAP));
		cls.reserved = data_byte[4:0] > cid_pkg::INFO_EIGHT_BYTE;
	end

	assign full = cnt_q == CW'(QDEPTH);
	assign head_valid = cnt_q != '0;
	assign head = q_mem[rd_ptr_q];
	assign wr_fire = push && !full;
	assign rd_fire = head_take && head_valid;

	always_ff @(posedge clk) begin
		if (wr_fire) begin
			q_mem[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_fire) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QDEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd_fire) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QDEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (wr_fire && !rd_fire) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (rd_fire && !wr_fire) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

/* rtl/core/cid_back.sv */
// Back end: head decoding, nesting stack and the result register.
module cid_back #(
	parameter int STACK_DEPTH = cid_pkg::STACK_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        msg_length,
	input  logic [9:0]         depth_limit,
	input  cid_pkg::byte_cls_t in_byte,
	input  logic               in_valid,
	output logic               in_take,
	output logic               empty,
	input  logic               pop,
	output logic [2:0]         status,
	output logic [31:0]        consumed,
	output logic [10:0]        level
);
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int MW  = $clog2(STACK_DEPTH);
	localparam int CW  = ((SPW > 10) ? SPW : 10) + 1;

	localparam logic [1:0] S_IDLE    = 2'd0;
	localparam logic [1:0] S_POP_DEC = 2'd1;
	localparam logic [1:0] S_POP_RD  = 2'd2;
	localparam logic [1:0] S_EMIT    = 2'd3;

	logic [1:0]     state_q;
	logic [31:0]    pos_q, pl_q;
	logic [3:0]     hbl_q;
	logic [63:0]    hv_q;
	logic [2:0]     major_q, outcome_q;
	logic [SPW-1:0] sp_q;
	logic [32:0]    top_q, rd_q;
	logic [32:0]    stack_mem [STACK_DEPTH];

	logic           out_valid_q;
	logic [2:0]     out_status_q;
	logic [31:0]    out_consumed_q;
	logic [10:0]    out_level_q;

	logic [31:0]    n_pos, n_pl;
	logic [3:0]     n_hbl;
	logic [63:0]    n_hv;
	logic [2:0]     n_major, n_outcome, emit_status;
	logic [32:0]    room, push_val;
	logic           head_done, whole, do_push, do_pop, push_we;
	logic [MW-1:0]  rd_addr;

	always_comb begin
		n_pos = pos_q;
		n_pl = pl_q;
		n_hbl = hbl_q;
		n_hv = hv_q;
		n_major = major_q;
		n_outcome = outcome_q;
		room = '0;
		push_val = '0;
		head_done = 1'b0;
		whole = 1'b0;
		do_push = 1'b0;
		do_pop = 1'b0;
		if (outcome_q != cid_pkg::ST_BUSY) begin
			if (outcome_q == cid_pkg::ST_DONE) begin
				n_outcome = cid_pkg::ST_TRAIL;
			end
		end else if (pos_q >= msg_length) begin
			n_outcome = cid_pkg::ST_END;
		end else begin
			n_pos = pos_q + 32'd1;
			if (pl_q != '0) begin
				n_pl = pl_q - 32'd1;
				whole = pl_q == 32'd1;
			end else if (hbl_q != '0) begin
				n_hv = {hv_q[55:0], in_byte.data};
				n_hbl = hbl_q - 4'd1;
				head_done = hbl_q == 4'd1;
			end else if (in_byte.simple) begin
				whole = 1'b1;
			end else if (in_byte.bad_type) begin
				n_outcome = cid_pkg::ST_TYPE;
			end else if (in_byte.reserved) begin
				n_outcome = cid_pkg::ST_RESERVED;
			end else begin
				n_major = in_byte.data[7:5];
				if (in_byte.data[4:0] < cid_pkg::INFO_ONE_BYTE) begin
					n_hv = {59'd0, in_byte.data[4:0]};
					head_done = 1'b1;
				end else begin
					n_hv = '0;
					n_hbl = 4'd1 << in_byte.data[1:0];
				end
			end
			if (head_done) begin
				room = {1'b0, msg_length} - {1'b0, n_pos};
				if (n_major == cid_pkg::MAJ_MAP) begin
					room = room >> 1;
				end
				if (n_major == cid_pkg::MAJ_UINT) begin
					whole = 1'b1;
				end else if ((n_hv[63:32] != '0) || ({1'b0, n_hv[31:0]} > room)) begin
					n_outcome = cid_pkg::ST_TOOLONG;
				end else if ((n_major == cid_pkg::MAJ_BSTR) || (n_major == cid_pkg::MAJ_TSTR)) begin
					n_pl = n_hv[31:0];
					whole = n_hv[31:0] == '0;
				end else begin
					// a map owes two items per entry
					push_val = (n_major == cid_pkg::MAJ_MAP) ? {n_hv[31:0], 1'b0}
						: {1'b0, n_hv[31:0]};
					if (push_val == '0) begin
						whole = 1'b1;
					end else if ((CW'(sp_q) + CW'(1) > CW'(depth_limit))
						|| (sp_q >= SPW'(STACK_DEPTH))) begin
						n_outcome = cid_pkg::ST_NESTING;
					end else begin
						do_push = 1'b1;
					end
				end
			end
			if (whole) begin
				if (sp_q == '0) begin
					n_outcome = cid_pkg::ST_DONE;
				end else begin
					do_pop = 1'b1;
				end
			end
		end
	end

	assign in_take = (state_q == S_IDLE) && in_valid && !out_valid_q;
	assign push_we = in_take && do_push && (sp_q != '0);
	assign rd_addr = MW'(sp_q - SPW'(2));
	assign emit_status = ((outcome_q == cid_pkg::ST_BUSY) && (pos_q >= msg_length))
		? cid_pkg::ST_END : outcome_q;

	// Top of stack lives in top_q; the memory holds the levels below it.
	always_ff @(posedge clk) begin
		if (push_we) begin
			stack_mem[MW'(sp_q - SPW'(1))] <= top_q;
		end
		rd_q <= stack_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q <= '0;
			pl_q <= '0;
			hbl_q <= '0;
			hv_q <= '0;
			major_q <= '0;
			outcome_q <= cid_pkg::ST_BUSY;
			sp_q <= '0;
			top_q <= '0;
			out_valid_q <= 1'b0;
			out_status_q <= '0;
			out_consumed_q <= '0;
			out_level_q <= '0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						pos_q <= n_pos;
						pl_q <= n_pl;
						hbl_q <= n_hbl;
						hv_q <= n_hv;
						major_q <= n_major;
						outcome_q <= n_outcome;
						if (do_push) begin
							top_q <= push_val;
							sp_q <= sp_q + SPW'(1);
						end
						state_q <= do_pop ? S_POP_DEC : S_EMIT;
					end
				end
				S_POP_DEC: begin
					// pay one item to the open container; close it when paid off
					if (top_q != 33'd1) begin
						top_q <= top_q - 33'd1;
						state_q <= S_EMIT;
					end else begin
						sp_q <= sp_q - SPW'(1);
						if (sp_q == SPW'(1)) begin
							outcome_q <= cid_pkg::ST_DONE;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_POP_RD;
						end
					end
				end
				S_POP_RD: begin
					top_q <= rd_q;
					state_q <= S_POP_DEC;
				end
				S_EMIT: begin
					outcome_q <= emit_status;
					out_valid_q <= 1'b1;
					out_status_q <= emit_status;
					out_consumed_q <= pos_q;
					out_level_q <= 11'(sp_q);
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign empty = !out_valid_q;
	assign status = out_status_q;
	assign consumed = out_consumed_q;
	assign level = out_level_q;

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> !out_valid_q)
		else $error("result written over a waiting result");

	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		((outcome_q != cid_pkg::ST_BUSY) && (outcome_q != cid_pkg::ST_DONE))
		|=> (outcome_q == $past(outcome_q)))
		else $error("error outcome changed");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP_DEC) |-> (sp_q != '0))
		else $error("pop with empty stack");

endmodule

/* rtl/core/cbor_item_delimiter.sv */
// Top level of the CBOR item delimiter: configuration registers, front and back ends.
//
//  channel   direction  handshake          payload
//  input     in         push / full        data_byte
//  result    out        pop / empty        status, consumed, level
//  config    in         wr_en              wr_index, wr_data
//
// A byte passes decode (S_IDLE) and result write (S_EMIT), then waits for the pop;
// it also passes S_POP_DEC when it pays an open container, and S_POP_RD and
// S_POP_DEC again for each container that closes above another open one. A waiting
// result stalls the back end; the front queue takes bytes until it is full.
// Reset clears all control state; the stack memory is never cleared, each
// level is written before it is read.
module cbor_item_delimiter #(
	parameter int STACK_DEPTH = cid_pkg::STACK_DEPTH_DEF,
	parameter int FQ_DEPTH    = cid_pkg::FQ_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [31:0] consumed,
	output logic [10:0] level,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [31:0] wr_data
);
	logic [31:0]        msg_length_q;
	logic [9:0]         depth_limit_q;
	cid_pkg::byte_cls_t head;
	logic               head_valid, head_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_length_q <= cid_pkg::MSG_LENGTH_RST;
			depth_limit_q <= cid_pkg::DEPTH_LIMIT_RST;
		end else if (wr_en) begin
			case (wr_index)
				cid_pkg::REG_MSG_LENGTH: msg_length_q <= wr_data;
				cid_pkg::REG_DEPTH_LIMIT: depth_limit_q <= wr_data[9:0];
				default: ;
			endcase
		end
	end

	cid_front #(
		.QDEPTH(FQ_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.head(head),
		.head_valid(head_valid),
		.head_take(head_take)
	);

	cid_back #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.msg_length(msg_length_q),
		.depth_limit(depth_limit_q),
		.in_byte(head),
		.in_valid(head_valid),
		.in_take(head_take),
		.empty(empty),
		.pop(pop),
		.status(status),
		.consumed(consumed),
		.level(level)
	);

endmodule
